[src/pdid_pkg.sv]
// Shared types and constants of the pack delta instruction decoder.
package pdid_pkg;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_REF  = 7'b0000001,
        PH_RES  = 7'b0000010,
        PH_OP   = 7'b0000100,
        PH_COPY = 7'b0001000,
        PH_LIT  = 7'b0010000,
        PH_END  = 7'b0100000,
        PH_ERR  = 7'b1000000
    } phase_t;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_COPY    = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    // Error codes
    localparam logic [1:0] ERR_SIZE_MISMATCH = 2'd0;
    localparam logic [1:0] ERR_SIZE_LARGE    = 2'd1;
    localparam logic [1:0] ERR_ZERO_OPCODE   = 2'd2;
    localparam logic [1:0] ERR_COPY_RANGE    = 2'd3;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_REFERENCE_SIZE = 3'd0;

    // Copy instruction constants
    localparam int PARAM_BYTES = 7;
    localparam int OFFSET_BYTES = 4;
    localparam logic [23:0] LEN_ZERO_ALIAS = 24'h010000;

    // One result item plus its valid flag
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  literal_byte;
        logic [31:0] copy_offset;
        logic [23:0] copy_length;
        logic        done_res;
        logic [1:0]  error_code;
    } result_t;

endpackage

[src/pdid_in_if.sv]
// Input channel of the delta decoder: one delta stream byte per item.
interface pdid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] delta_byte;
    logic       start_of_delta;

    modport source (output valid, output delta_byte, output start_of_delta, input ready);
    modport sink (input valid, input delta_byte, input start_of_delta, output ready);
endinterface

[src/pdid_out_if.sv]
// Output channel of the delta decoder: one decoded result per item.
interface pdid_out_if;
    logic                valid;
    logic                ready;
    pdid_pkg::kind_t     kind;
    logic [7:0]          literal_byte;
    logic [31:0]         copy_offset;
    logic [23:0]         copy_length;
    logic                done_res;
    logic [1:0]          error_code;

    modport source (output valid, output kind, output literal_byte, output copy_offset,
                    output copy_length, output done_res, output error_code, input ready);
    modport sink (input valid, input kind, input literal_byte, input copy_offset,
                  input copy_length, input done_res, input error_code, output ready);
endinterface

[src/pack_delta_instruction_decoder.sv]
// Top level of the pack delta instruction decoder.

// Decodes an inflated delta stream, one byte per item, at a sustained rate of one item
// per clock while the output is not stalled. Each item is held in an input register,
// decoded by the parser logic, and its result (if any) lands in an output register; a
// stalled output only holds the pipe once both registers are full. Size varint and copy
// parameter bytes give no result but errors and an empty result's done; the last byte
// of a copy gives the copy command, each literal byte gives itself. Errors are sticky
// until an item with start_of_delta set. reference_size is written over the APB port
// at address 0 and must only change while the decoder is idle.
module pack_delta_instruction_decoder #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pdid_in_if.sink                       in_ch,
    pdid_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdid_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SW  = SIZE_WIDTH;
    localparam int SHW = $clog2(SIZE_WIDTH + 8);
    localparam int CW  = (SIZE_WIDTH > 32) ? SIZE_WIDTH : 32;
    localparam int PW  = ((SIZE_WIDTH > 24) ? SIZE_WIDTH : 24) + 1;

    // Configuration register, decoded on the word address
    logic [31:0] ref_size_reg;
    logic        ref_size_sel;

    assign ref_size_sel = (paddr[pdid_pkg::ADDR_W-1:2]
                           == pdid_pkg::ADDR_REFERENCE_SIZE[pdid_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;
    assign prdata = ref_size_sel ? ref_size_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_size_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && ref_size_sel)
        begin
            ref_size_reg <= pwdata;
        end
    end

    // Pipeline registers
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                s1_start_reg;
    logic                out_valid_reg;
    pdid_pkg::result_t   out_reg;
    logic                advance;

    // Parser state
    pdid_pkg::phase_t    phase_reg, phase_next;
    logic [SW-1:0]       acc_reg, acc_next;
    logic [SHW-1:0]      shift_reg, shift_next;
    logic [SW-1:0]       target_reg, target_next;
    logic [SW-1:0]       produced_reg, produced_next;
    logic [6:0]          mask_reg, mask_next;
    logic [31:0]         offset_reg, offset_next;
    logic [23:0]         length_reg, length_next;
    logic [6:0]          lit_rem_reg, lit_rem_next;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    // Start of delta overrides the held state
    pdid_pkg::phase_t    phase_cur;
    logic [SW-1:0]       acc_cur;
    logic [SHW-1:0]      shift_cur;
    logic [SW-1:0]       produced_cur;

    assign phase_cur    = s1_start_reg ? pdid_pkg::PH_REF : phase_reg;
    assign acc_cur      = s1_start_reg ? '0 : acc_reg;
    assign shift_cur    = s1_start_reg ? '0 : shift_reg;
    assign produced_cur = s1_start_reg ? '0 : produced_reg;

    // Varint byte: payload bits placed at the current shift, overflow check
    logic [6:0]          vi_pay;
    logic [SW+6:0]       vi_wide;
    logic [SW+6:0]       vi_shifted;
    logic                vi_over;
    logic                vi_last;
    logic [SW-1:0]       vi_acc;
    logic [SHW-1:0]      vi_shift;
    logic                ref_mismatch;

    assign vi_pay     = s1_byte_reg[6:0];
    assign vi_wide    = {{SW{1'b0}}, vi_pay};
    assign vi_shifted = vi_wide << shift_cur;
    assign vi_over    = (vi_pay != 7'd0)
                        && ((shift_cur >= SHW'(SW)) || (vi_shifted[SW+6:SW] != 7'd0));
    assign vi_last    = !s1_byte_reg[7];
    assign vi_acc     = acc_cur | vi_shifted[SW-1:0];
    assign vi_shift   = (shift_cur < SHW'(SW)) ? shift_cur + SHW'(7) : shift_cur;
    assign ref_mismatch = CW'(vi_acc) != CW'(ref_size_reg);

    // Copy parameter gathering: next byte fills the lowest selected slot
    logic [6:0]          sel;
    logic [6:0]          mask_left;
    logic [31:0]         gather_off;
    logic [23:0]         gather_len;

    assign sel       = mask_reg & (~mask_reg + 7'd1);
    assign mask_left = mask_reg & ~sel;

    always_comb
    begin
        gather_off = offset_reg;
        gather_len = length_reg;
        for (int i = 0; i < pdid_pkg::OFFSET_BYTES; i++)
        begin
            if (sel[i])
            begin
                gather_off[8*i +: 8] = s1_byte_reg;
            end
        end
        for (int i = 0; i < pdid_pkg::PARAM_BYTES - pdid_pkg::OFFSET_BYTES; i++)
        begin
            if (sel[pdid_pkg::OFFSET_BYTES + i])
            begin
                gather_len[8*i +: 8] = s1_byte_reg;
            end
        end
    end

    // Copy bounds check and produced byte count
    logic [31:0]         copy_off;
    logic [23:0]         copy_len;
    logic [23:0]         len_eff;
    logic [32:0]         copy_end;
    logic                copy_oob;
    logic [23:0]         prod_inc;
    logic [PW-1:0]       prod_sum;
    logic [SW-1:0]       prod_new;
    logic                prod_done;

    assign copy_off  = (phase_cur == pdid_pkg::PH_COPY) ? gather_off : 32'd0;
    assign copy_len  = (phase_cur == pdid_pkg::PH_COPY) ? gather_len : 24'd0;
    assign len_eff   = (copy_len == 24'd0) ? pdid_pkg::LEN_ZERO_ALIAS : copy_len;
    assign copy_end  = {1'b0, copy_off} + 33'(len_eff);
    assign copy_oob  = copy_end > {1'b0, ref_size_reg};
    assign prod_inc  = (phase_cur == pdid_pkg::PH_LIT) ? 24'd1 : len_eff;
    assign prod_sum  = PW'(produced_cur) + PW'(prod_inc);
    assign prod_new  = (prod_sum > PW'({SW{1'b1}})) ? {SW{1'b1}} : prod_sum[SW-1:0];
    assign prod_done = prod_new >= target_reg;

    // Parser step
    pdid_pkg::result_t   res;
    logic                do_copy;

    always_comb
    begin
        phase_next    = phase_cur;
        acc_next      = acc_cur;
        shift_next    = shift_cur;
        target_next   = s1_start_reg ? '0 : target_reg;
        produced_next = produced_cur;
        mask_next     = mask_reg;
        offset_next   = offset_reg;
        length_next   = length_reg;
        lit_rem_next  = lit_rem_reg;
        do_copy       = 1'b0;
        res           = '0;
        res.kind      = pdid_pkg::KIND_LITERAL;

        unique case (phase_cur)
            pdid_pkg::PH_REF:
            begin
                if (vi_over)
                begin
                    phase_next     = pdid_pkg::PH_ERR;
                    res.valid      = 1'b1;
                    res.kind       = pdid_pkg::KIND_ERROR;
                    res.error_code = pdid_pkg::ERR_SIZE_LARGE;
                end
                else if (vi_last)
                begin
                    acc_next   = '0;
                    shift_next = '0;
                    if (ref_mismatch)
                    begin
                        phase_next     = pdid_pkg::PH_ERR;
                        res.valid      = 1'b1;
                        res.kind       = pdid_pkg::KIND_ERROR;
                        res.error_code = pdid_pkg::ERR_SIZE_MISMATCH;
                    end
                    else
                    begin
                        phase_next = pdid_pkg::PH_RES;
                    end
                end
                else
                begin
                    acc_next   = vi_acc;
                    shift_next = vi_shift;
                end
            end
            pdid_pkg::PH_RES:
            begin
                if (vi_over)
                begin
                    phase_next     = pdid_pkg::PH_ERR;
                    res.valid      = 1'b1;
                    res.kind       = pdid_pkg::KIND_ERROR;
                    res.error_code = pdid_pkg::ERR_SIZE_LARGE;
                end
                else if (vi_last)
                begin
                    acc_next    = '0;
                    shift_next  = '0;
                    target_next = vi_acc;
                    if (produced_cur >= vi_acc)
                    begin
                        // empty result object
                        phase_next   = pdid_pkg::PH_END;
                        res.valid    = 1'b1;
                        res.kind     = pdid_pkg::KIND_DONE;
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        phase_next = pdid_pkg::PH_OP;
                    end
                end
                else
                begin
                    acc_next   = vi_acc;
                    shift_next = vi_shift;
                end
            end
            pdid_pkg::PH_OP:
            begin
                if (s1_byte_reg == 8'd0)
                begin
                    phase_next     = pdid_pkg::PH_ERR;
                    res.valid      = 1'b1;
                    res.kind       = pdid_pkg::KIND_ERROR;
                    res.error_code = pdid_pkg::ERR_ZERO_OPCODE;
                end
                else if (s1_byte_reg[7])
                begin
                    mask_next   = s1_byte_reg[6:0];
                    offset_next = 32'd0;
                    length_next = 24'd0;
                    phase_next  = pdid_pkg::PH_COPY;
                    do_copy     = (s1_byte_reg[6:0] == 7'd0);
                end
                else
                begin
                    lit_rem_next = s1_byte_reg[6:0];
                    phase_next   = pdid_pkg::PH_LIT;
                end
            end
            pdid_pkg::PH_COPY:
            begin
                mask_next   = mask_left;
                offset_next = gather_off;
                length_next = gather_len;
                do_copy     = (mask_left == 7'd0);
            end
            pdid_pkg::PH_LIT:
            begin
                produced_next    = prod_new;
                lit_rem_next     = lit_rem_reg - 7'd1;
                res.valid        = 1'b1;
                res.kind         = pdid_pkg::KIND_LITERAL;
                res.literal_byte = s1_byte_reg;
                if (lit_rem_reg == 7'd1)
                begin
                    phase_next   = prod_done ? pdid_pkg::PH_END : pdid_pkg::PH_OP;
                    res.done_res = prod_done;
                end
            end
            pdid_pkg::PH_END, pdid_pkg::PH_ERR:
            begin
                // bytes are dropped until the next start of delta
            end
            default:
            begin
            end
        endcase

        // Copy command, or range error, once all selected parameter bytes are in
        if (do_copy)
        begin
            res.valid = 1'b1;
            if (copy_oob)
            begin
                phase_next     = pdid_pkg::PH_ERR;
                res.kind       = pdid_pkg::KIND_ERROR;
                res.error_code = pdid_pkg::ERR_COPY_RANGE;
            end
            else
            begin
                produced_next   = prod_new;
                phase_next      = prod_done ? pdid_pkg::PH_END : pdid_pkg::PH_OP;
                res.kind        = pdid_pkg::KIND_COPY;
                res.copy_offset = copy_off;
                res.copy_length = len_eff;
                res.done_res    = prod_done;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg  <= in_ch.delta_byte;
            s1_start_reg <= in_ch.start_of_delta;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= pdid_pkg::PH_REF;
            acc_reg      <= '0;
            shift_reg    <= '0;
            target_reg   <= '0;
            produced_reg <= '0;
            mask_reg     <= 7'd0;
            offset_reg   <= 32'd0;
            length_reg   <= 24'd0;
            lit_rem_reg  <= 7'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            shift_reg    <= shift_next;
            target_reg   <= target_next;
            produced_reg <= produced_next;
            mask_reg     <= mask_next;
            offset_reg   <= offset_next;
            length_reg   <= length_next;
            lit_rem_reg  <= lit_rem_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_reg.kind;
    assign out_ch.literal_byte = out_reg.literal_byte;
    assign out_ch.copy_offset  = out_reg.copy_offset;
    assign out_ch.copy_length  = out_reg.copy_length;
    assign out_ch.done_res     = out_reg.done_res;
    assign out_ch.error_code   = out_reg.error_code;

    // An error result leaves the parser in the error phase
    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid && res.kind == pdid_pkg::KIND_ERROR
        |=> phase_reg == pdid_pkg::PH_ERR)
        else $error("error result did not park the parser");

    // A result that ends the delta leaves the parser in the end phase
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid && res.done_res
        |=> phase_reg == pdid_pkg::PH_END)
        else $error("done result did not end the delta");

    // The produced count only grows within one delta
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !s1_start_reg |=> produced_reg >= $past(produced_reg))
        else $error("produced count went backward");

    // Input stalls only when both pipeline registers hold items
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && out_valid_reg && !out_ch.ready)
        else $error("input stalled with room in the pipeline");

endmodule

[sim/pack_delta_instruction_decoder_tb.sv]
// Testbench for the pack delta instruction decoder: directed and random deltas against a predictor.
module pack_delta_instruction_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 600000;
    localparam int LONG_STALL = 250;
    localparam int ITEMS_PER_SETTING = 85;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [pdid_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pdid_in_if in_ch();
    pdid_out_if out_ch();

    pack_delta_instruction_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder state as predicted
    logic [31:0]      ref_size_cfg;
    pdid_pkg::phase_t dp_phase;
    logic [63:0]      dp_acc;
    int               dp_shift;
    logic [31:0]      dp_target;
    logic [31:0]      dp_produced;
    logic [7:0]       dp_opcode;
    int               dp_param;
    logic [31:0]      dp_offset;
    logic [23:0]      dp_length;
    int               dp_literal_left;
    logic             byte_was_live;

    pdid_pkg::result_t pending_results[$];

    int mismatch_count;
    int cycle_count;
    int bytes_sent;
    int live_items;
    int settings_used;
    int literal_seen;
    int copy_seen;
    int error_seen;
    int done_seen;
    bit no_gap;
    int long_stall_seq;
    int long_stall_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_decoder_state();
        dp_phase = pdid_pkg::PH_REF;
        dp_acc = '0;
        dp_shift = 0;
        dp_target = '0;
        dp_produced = '0;
        dp_opcode = '0;
        dp_param = 0;
        dp_offset = '0;
        dp_length = '0;
        dp_literal_left = 0;
    endfunction

    function automatic pdid_pkg::result_t make_result(pdid_pkg::kind_t k, logic [7:0] lit,
                                                      logic [31:0] off, logic [23:0] len,
                                                      logic done, logic [1:0] err);
        pdid_pkg::result_t r;
        r.valid = 1'b1;
        r.kind = k;
        r.literal_byte = lit;
        r.copy_offset = off;
        r.copy_length = len;
        r.done_res = done;
        r.error_code = err;
        return r;
    endfunction

    function automatic pdid_pkg::result_t raise_error(logic [1:0] code);
        dp_phase = pdid_pkg::PH_ERR;
        return make_result(pdid_pkg::KIND_ERROR, '0, '0, '0, 1'b0, code);
    endfunction

    // 0: more bytes follow, 1: size complete, 2: size too large
    function automatic int absorb_size_byte(logic [7:0] b);
        logic [63:0] payload;
        int s;
        payload = {57'd0, b[6:0]};
        s = dp_shift;
        if (payload != 0)
        begin
            if (s >= 32)
                return 2;
            if (32 - s < 7 && (payload >> (32 - s)) != 0)
                return 2;
            dp_acc = dp_acc | (payload << s);
        end
        if (s < 64)
            dp_shift = s + 7;
        return b[7] ? 0 : 1;
    endfunction

    // Saturating byte counter
    function automatic void add_produced(logic [32:0] n);
        if (dp_produced == 32'hFFFF_FFFF || n > ({1'b0, 32'hFFFF_FFFF} - {1'b0, dp_produced}))
            dp_produced = 32'hFFFF_FFFF;
        else
            dp_produced = dp_produced + n[31:0];
    endfunction

    function automatic logic end_check();
        if (dp_produced >= dp_target)
        begin
            dp_phase = pdid_pkg::PH_END;
            return 1'b1;
        end
        dp_phase = pdid_pkg::PH_OP;
        return 1'b0;
    endfunction

    // Skip parameter bytes the opcode does not select; 1 when none are left
    function automatic logic skip_params();
        while (dp_param < pdid_pkg::PARAM_BYTES && !dp_opcode[dp_param])
            dp_param++;
        return dp_param >= pdid_pkg::PARAM_BYTES;
    endfunction

    function automatic pdid_pkg::result_t finish_copy();
        logic [32:0] len;
        logic done;
        len = (dp_length == 0) ? {9'd0, pdid_pkg::LEN_ZERO_ALIAS} : {9'd0, dp_length};
        if (dp_offset > ref_size_cfg || len > ({1'b0, ref_size_cfg} - {1'b0, dp_offset}))
            return raise_error(pdid_pkg::ERR_COPY_RANGE);
        add_produced(len);
        done = end_check();
        return make_result(pdid_pkg::KIND_COPY, '0, dp_offset, len[23:0], done, 2'd0);
    endfunction

    function automatic pdid_pkg::result_t predict_decode(logic [7:0] b, logic sod);
        pdid_pkg::result_t none;
        int r;
        logic [63:0] size_val;
        logic done;
        none = '0;
        if (sod)
            clear_decoder_state();
        byte_was_live = (dp_phase != pdid_pkg::PH_END && dp_phase != pdid_pkg::PH_ERR);
        case (dp_phase)
            pdid_pkg::PH_REF:
            begin
                r = absorb_size_byte(b);
                if (r == 2)
                    return raise_error(pdid_pkg::ERR_SIZE_LARGE);
                if (r == 1)
                begin
                    size_val = dp_acc;
                    dp_acc = '0;
                    dp_shift = 0;
                    if (size_val != {32'd0, ref_size_cfg})
                        return raise_error(pdid_pkg::ERR_SIZE_MISMATCH);
                    dp_phase = pdid_pkg::PH_RES;
                end
                return none;
            end
            pdid_pkg::PH_RES:
            begin
                r = absorb_size_byte(b);
                if (r == 2)
                    return raise_error(pdid_pkg::ERR_SIZE_LARGE);
                if (r == 1)
                begin
                    dp_target = dp_acc[31:0];
                    dp_acc = '0;
                    dp_shift = 0;
                    if (end_check())
                        return make_result(pdid_pkg::KIND_DONE, '0, '0, '0, 1'b1, 2'd0);
                end
                return none;
            end
            pdid_pkg::PH_OP:
            begin
                dp_opcode = b;
                if (b == 8'h00)
                    return raise_error(pdid_pkg::ERR_ZERO_OPCODE);
                if (b[7])
                begin
                    dp_param = 0;
                    dp_offset = '0;
                    dp_length = '0;
                    dp_phase = pdid_pkg::PH_COPY;
                    if (skip_params())
                        return finish_copy();
                    return none;
                end
                dp_literal_left = b[6:0];
                dp_phase = pdid_pkg::PH_LIT;
                return none;
            end
            pdid_pkg::PH_COPY:
            begin
                if (dp_param < pdid_pkg::OFFSET_BYTES)
                    dp_offset[8*dp_param +: 8] = b;
                else if (dp_param < pdid_pkg::PARAM_BYTES)
                    dp_length[8*(dp_param - pdid_pkg::OFFSET_BYTES) +: 8] = b;
                dp_param++;
                if (skip_params())
                    return finish_copy();
                return none;
            end
            pdid_pkg::PH_LIT:
            begin
                done = 1'b0;
                add_produced(33'd1);
                if (dp_literal_left > 0)
                    dp_literal_left--;
                if (dp_literal_left == 0)
                    done = end_check();
                return make_result(pdid_pkg::KIND_LITERAL, b, '0, '0, done, 2'd0);
            end
            default:
                return none;
        endcase
    endfunction

    // ---------------------------------------------------------------- result checking

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pdid_pkg::result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected, kind %0d", out_ch.kind);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, out_ch.kind);
                check_field("literal_byte", want.literal_byte, out_ch.literal_byte);
                check_field("copy_offset", want.copy_offset, out_ch.copy_offset);
                check_field("copy_length", want.copy_length, out_ch.copy_length);
                check_field("done_res", want.done_res, out_ch.done_res);
                check_field("error_code", want.error_code, out_ch.error_code);
                case (want.kind)
                    pdid_pkg::KIND_LITERAL: literal_seen++;
                    pdid_pkg::KIND_COPY:    copy_seen++;
                    pdid_pkg::KIND_ERROR:   error_seen++;
                    default:                done_seen++;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- result side stalls
    initial
    begin
        int hold;
        int stretch;
        int r;
        int seen_seq;
        out_ch.ready = 1'b0;
        hold = 0;
        stretch = 0;
        seen_seq = 0;
        forever
        begin
            @(posedge clk);
            if (long_stall_seq != seen_seq)
            begin
                seen_seq = long_stall_seq;
                hold = long_stall_cycles;
            end
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else if (stretch > 0)
            begin
                stretch--;
                out_ch.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(99, 0);
                out_ch.ready <= (r < 70);
                if (r < 5)
                    stretch = $urandom_range(120, 20);
                else if (r >= 70)
                    hold = (r < 95) ? $urandom_range(2, 0) : $urandom_range(40, 8);
            end
        end
    end

    // Cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pack_delta_instruction_decoder_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_gap();
        int r;
        if (no_gap)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(25, 4);
    endfunction

    // Offer one delta byte, wait for acceptance, record what it should produce
    task automatic send_byte(logic [7:0] b, logic sod);
        pdid_pkg::result_t r;
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.delta_byte <= b;
        in_ch.start_of_delta <= sod;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        r = predict_decode(b, sod);
        if (r.valid)
            pending_results.push_back(r);
        bytes_sent++;
        if (byte_was_live)
            live_items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Pause input until every expected result is in, then idle a while
    task automatic wait_drained(int extra);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // Base-128 little-endian size, optionally followed by zero padding bytes
    task automatic send_size_varint(logic [63:0] v, int pad, logic sod_first);
        logic [7:0] b;
        logic first;
        first = sod_first;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0 || pad > 0)
                b[7] = 1'b1;
            send_byte(b, first);
            first = 1'b0;
        end
        while (v != 0);
        while (pad > 0)
        begin
            pad--;
            send_byte((pad > 0) ? 8'h80 : 8'h00, 1'b0);
        end
    endtask

    task automatic send_copy_op(logic [7:0] op, logic [31:0] off, logic [23:0] len);
        logic [55:0] params;
        params = {len, off};
        send_byte(op, 1'b0);
        for (int i = 0; i < pdid_pkg::PARAM_BYTES; i++)
            if (op[i])
                send_byte(params[8*i +: 8], 1'b0);
    endtask

    // Copy with every nonzero byte selected and some zero bytes sent explicitly
    task automatic send_copy(logic [31:0] off, logic [23:0] len);
        logic [55:0] params;
        logic [7:0] op;
        params = {len, off};
        op = 8'h80;
        for (int i = 0; i < pdid_pkg::PARAM_BYTES; i++)
            if (params[8*i +: 8] != 0 || $urandom_range(3, 0) == 0)
                op[i] = 1'b1;
        send_copy_op(op, off, len);
    endtask

    task automatic send_literal_run(int n);
        send_byte(8'(n), 1'b0);
        repeat (n) send_byte(8'($urandom_range(255, 0)), 1'b0);
    endtask

    // APB write followed by a read back of the same register
    task automatic set_reference_size(logic [31:0] value);
        wait_drained(DRAIN_CYCLES);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pdid_pkg::ADDR_REFERENCE_SIZE;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        ref_size_cfg = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        check_field("reference_size readback", value, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_register_access();
        set_reference_size(32'hFFFF_FFFF);
        set_reference_size(32'h0000_0000);
        set_reference_size(32'hA5A5_5A5A);
    endtask

    // Empty and partial copy opcodes, exact end of reference, range error
    task automatic test_copy_forms();
        set_reference_size(32'h89AB_CDEF);
        send_size_varint(64'h89AB_CDEF, 0, 1'b1);
        send_size_varint(64'hFFFF_FFF0, 0, 1'b0);
        send_copy_op(8'hF8, 32'h8000_0000, 24'hFF_FFFF);
        send_copy_op(8'h80, 32'h0, 24'h0);
        send_copy_op(8'h91, 32'h0000_00FF, 24'h00_0001);
        send_copy_op(8'h9F, 32'h89AB_CDDF, 24'h00_0010);
        send_copy_op(8'h8F, 32'h89AB_CDEF, 24'h0);
        send_byte(8'h01, 1'b0);
    endtask

    // A literal run finishes past the result size before done is flagged
    task automatic test_literal_runs();
        set_reference_size(32'h0);
        send_size_varint(64'h0, 0, 1'b1);
        send_size_varint(64'd3, 0, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    // Size mismatch, oversized sizes, zero padding, zero opcode
    task automatic test_size_errors();
        send_size_varint(64'd1, 0, 1'b1);
        send_byte(8'h00, 1'b0);
        send_size_varint(64'h1_0000_0000, 0, 1'b1);
        send_size_varint(64'h0, 9, 1'b1);
        send_size_varint(64'h8_0000_0000, 0, 1'b0);
        send_size_varint(64'h0, 0, 1'b1);
        send_size_varint(64'd5, 0, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Zero result size, bytes after done, restart in the middle of a literal run
    task automatic test_empty_result();
        send_size_varint(64'h0, 0, 1'b1);
        send_size_varint(64'h0, 0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_size_varint(64'h0, 0, 1'b1);
        send_size_varint(64'h7F0, 0, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h11, 1'b0);
        send_size_varint(64'h0, 0, 1'b1);
        send_size_varint(64'h0, 0, 1'b0);
    endtask

    // Long result stall while bytes keep coming, then a full pause of the input
    task automatic test_backpressure();
        set_reference_size(32'h0000_0100);
        send_size_varint(64'h100, 0, 1'b1);
        send_size_varint(64'd400, 0, 1'b0);
        no_gap = 1'b1;
        long_stall_cycles = LONG_STALL;
        long_stall_seq++;
        send_literal_run(127);
        wait_drained(0);
        send_literal_run(3);
        send_copy(32'h0000_0020, 24'h00_0040);
        no_gap = 1'b0;
    endtask

    // One random delta: mostly well formed, some noise and broken streams
    task automatic send_random_delta();
        int r;
        int n_instr;
        int k;
        logic [63:0] size_enc;
        logic [31:0] off;
        logic [31:0] room;
        logic [31:0] cap;
        logic [23:0] len;
        r = $urandom_range(99, 0);
        if (r < 4)
        begin
            repeat ($urandom_range(12, 1))
                send_byte(8'($urandom_range(255, 0)), $urandom_range(9, 0) == 0);
            return;
        end
        size_enc = {32'd0, ref_size_cfg};
        if (r < 8)
            size_enc = size_enc + 64'd1;
        else if (r < 11)
            size_enc = size_enc | (64'($urandom_range(255, 1)) << 32);
        send_size_varint(size_enc,
                         ($urandom_range(9, 0) == 0) ? $urandom_range(6, 1) : 0, 1'b1);
        if (dp_phase == pdid_pkg::PH_ERR)
            return;
        k = $urandom_range(99, 0);
        if (k < 10)
            size_enc = 64'd0;
        else if (k < 55)
            size_enc = 64'($urandom_range(200, 1));
        else if (k < 85)
            size_enc = 64'($urandom_range(70000, 201));
        else
            size_enc = 64'($urandom());
        if (r >= 11 && r < 14)
            size_enc = size_enc | (64'($urandom_range(127, 1)) << 32);
        send_size_varint(size_enc,
                         ($urandom_range(9, 0) == 0) ? $urandom_range(4, 1) : 0, 1'b0);
        n_instr = $urandom_range(20, 1);
        k = 0;
        while (k < n_instr && dp_phase == pdid_pkg::PH_OP)
        begin
            r = $urandom_range(99, 0);
            if (r < 2)
                send_byte(8'h00, 1'b0);
            else if (r < 4)
            begin
                // abandon the delta inside a copy; the next one restarts the parser
                send_byte(8'h80 | 8'($urandom_range(127, 1)), 1'b0);
                return;
            end
            else if (r < 50)
                send_literal_run((r < 47) ? $urandom_range(8, 1) : $urandom_range(127, 9));
            else
            begin
                r = $urandom_range(99, 0);
                if (r < 6)
                begin
                    off = $urandom();
                    len = 24'($urandom());
                end
                else
                begin
                    if (r < 14)
                        off = ref_size_cfg - ((ref_size_cfg > 16) ? $urandom_range(16, 0) : 0);
                    else
                        off = $urandom_range(ref_size_cfg, 0);
                    room = ref_size_cfg - off;
                    if ($urandom_range(9, 0) == 0)
                        len = 24'h0;
                    else
                    begin
                        case ($urandom_range(3, 0))
                            0: cap = 32'd16;
                            1: cap = 32'd300;
                            2: cap = 32'd70000;
                            default: cap = 32'h00FF_FFFF;
                        endcase
                        if (room < cap)
                            cap = room;
                        len = (cap == 0) ? 24'd1 : 24'($urandom_range(cap, 1));
                    end
                end
                send_copy(off, len);
            end
            k++;
        end
        // trailing bytes; they are ignored only after done or an error
        if ($urandom_range(3, 0) == 0)
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255, 0)), 1'b0);
    endtask

    task automatic test_random_deltas();
        logic [31:0] sizes[6];
        int phase_start;
        sizes[0] = 32'hFFFF_FFFF;
        sizes[1] = 32'h0000_0000;
        sizes[2] = 32'($urandom_range(400, 1));
        sizes[3] = 32'h0001_0000;
        sizes[4] = $urandom();
        sizes[5] = 32'($urandom_range(32'h00FF_FFFF, 32'h0000_1000));
        foreach (sizes[i])
        begin
            set_reference_size(sizes[i]);
            phase_start = live_items;
            while (live_items - phase_start < ITEMS_PER_SETTING)
            begin
                no_gap = ($urandom_range(4, 0) == 0);
                send_random_delta();
            end
            no_gap = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- main sequence
    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.delta_byte = 8'h00;
        in_ch.start_of_delta = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ref_size_cfg = '0;
        clear_decoder_state();
        mismatch_count = 0;
        bytes_sent = 0;
        live_items = 0;
        settings_used = 0;
        literal_seen = 0;
        copy_seen = 0;
        error_seen = 0;
        done_seen = 0;
        no_gap = 1'b0;
        long_stall_seq = 0;
        long_stall_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_copy_forms();
        test_literal_runs();
        test_size_errors();
        test_empty_result();
        test_backpressure();
        test_random_deltas();

        wait_drained(DRAIN_CYCLES);
        $display("Sent %0d delta bytes (%0d decoded) under %0d reference size settings.",
                 bytes_sent, live_items, settings_used);
        $display("Checked %0d literal, %0d copy, %0d error and %0d done-only results.",
                 literal_seen, copy_seen, error_seen, done_seen);
        if (mismatch_count == 0)
            $display("pack_delta_instruction_decoder_tb passed");
        else
            $display("pack_delta_instruction_decoder_tb failed");
        $finish;
    end

endmodule
